@@ rtl/core/lpgs_pkg.sv @@
// Shared types, codes and helpers of the projected Gauss-Seidel solver.
`timescale 1ns / 1ps
package lpgs_pkg;

    // Request codes carried by the input channel.
    typedef enum logic [1:0] {
        REQ_MAT   = 2'd0,
        REQ_Q     = 2'd1,
        REQ_Z     = 2'd2,
        REQ_START = 2'd3
    } t_req;

    // Solve outcome codes.
    typedef enum logic [1:0] {
        ST_CONV  = 2'd0,
        ST_LIMIT = 2'd1,
        ST_DIAG  = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_MAXIT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    // Width of the exact accumulator.
    localparam int unsigned ACC_W = 64;

    typedef logic [3:0] t_idx;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LDQ,
        ACC_LDNQ,
        ACC_ADD,
        ACC_SUB,
        ACC_CLR
    } t_acc_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ld_wr;
        logic    rd_en;
        t_idx    row;
        t_idx    col;
        logic    mul_en;
        logic    mul_dot;
        t_acc_op acc_op;
        logic    w_we;
        logic    z_we;
        logic    chk_init;
        logic    div_start;
        logic    out_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic diag_zero;
        logic conv;
        logic div_done;
    } t_dpst;

    // Saturate an exact sum to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-31){1'b0}}, 31'h7FFF_FFFF})) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < $signed({{(ACC_W-31){1'b1}}, 31'h0})) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/lcp_projected_gauss_seidel.sv @@
// Top level of the projected Gauss-Seidel LCP solver with its register port.
`timescale 1ns / 1ps
// Usage: the input channel (i_valid/o_stall) carries load requests that write
// an entry of M, q or the warm-start z, one per cycle while the block is idle,
// and a start request. A start request holds o_stall high for the whole
// solve: a diagonal scan, then per pass a check and a dot product, and a
// sweep with one division per index, on a shared multiplier, one RAM read
// per step and a bit-serial divider. Then one result per index goes
// out on the output channel (o_valid/i_stall), o_last on the final one; each
// result is read from the stores and then loaded into the output register.
// A stalled result holds in the output register; the block waits for it and
// accepts new loads once the final result of a solve has been registered.
// Synchronous reset clears the controller, the z and w stores (they read as
// zero) and restores the register defaults: size 16, 100 iterations,
// tolerance 66.
module lcp_projected_gauss_seidel #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_col,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_index,
    output logic signed [31:0] o_z_value,
    output logic signed [31:0] o_w_value,
    output logic [1:0]         o_status,
    output logic [15:0]        o_iterations,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lpgs_pkg::*;

    logic [4:0]  r_size;
    logic [15:0] r_max_iter;
    logic [30:0] r_tol;
    logic        cfg_wr;
    t_cmd        cmd;
    t_dpst       st;

    // Register port writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= 5'd16;
            r_max_iter <= 16'd100;
            r_tol      <= 31'd66;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SIZE:  r_size     <= pwdata[4:0];
                REG_MAXIT: r_max_iter <= pwdata[15:0];
                REG_TOL:   r_tol      <= pwdata[30:0];
                default:   r_size     <= r_size;
            endcase
        end
    end

    // Register port reads.
    always_comb begin
        case (paddr[3:2])
            REG_SIZE:  prdata = {27'd0, r_size};
            REG_MAXIT: prdata = {16'd0, r_max_iter};
            REG_TOL:   prdata = {1'b0, r_tol};
            default:   prdata = '0;
        endcase
    end

    lpgs_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_req_type(i_req_type),
        .o_stall(o_stall), .i_stall(i_stall), .o_valid(o_valid), .o_index(o_index),
        .o_status(o_status), .o_iterations(o_iterations), .o_last(o_last),
        .i_size(r_size), .i_max_iter(r_max_iter), .o_cmd(cmd), .i_st(st)
    );

    lpgs_dp #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req_type(i_req_type),
        .i_row(i_row), .i_col(i_col), .i_value(i_value), .i_tol(r_tol),
        .o_st(st), .o_z_value(o_z_value), .o_w_value(o_w_value)
    );

    // While a result other than the final one waits, the solve still owns the block.
    a_busy_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input accepted while results of a solve are pending");

    // After the final result is taken, the next result starts a new solve.
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !i_stall) |=> (!o_valid || (o_index == 4'd0)))
        else $error("result index did not restart after the final result");

    // A zero diagonal reports no sweeps.
    a_diag_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DIAG)) |-> (o_iterations == 16'd0))
        else $error("zero-diagonal result with nonzero iteration count");
endmodule

@@ rtl/core/lpgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/lpgs_div.sv @@
// Iterative restoring divider for the sweep update, one quotient bit per cycle.
`timescale 1ns / 1ps
module lpgs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [DW-1:0] r_quo;
    logic          r_neg;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] rem_sh;
    logic        ge;

    assign num_mag = i_num[31] ? (32'd0 - i_num) : i_num;
    assign den_mag = i_den[31] ? (32'd0 - i_den) : i_den;
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes in, one shift-subtract step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_rem <= '0;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    // A negative quotient clamps to zero; a large one saturates.
    always_comb begin
        if (r_neg) begin
            o_quo = '0;
        end else if (|r_quo[DW-1:31]) begin
            o_quo = 32'sh7FFF_FFFF;
        end else begin
            o_quo = {1'b0, r_quo[30:0]};
        end
    end

    assign o_done = r_done;
endmodule

@@ rtl/core/lpgs_dp.sv @@
// Datapath: stores, multiplier, accumulator, divider and output registers.
`timescale 1ns / 1ps
module lpgs_dp #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpgs_pkg::t_cmd      i_cmd,
    input  logic [1:0]          i_req_type,
    input  logic [3:0]          i_row,
    input  logic [3:0]          i_col,
    input  logic signed [31:0]  i_value,
    input  logic [30:0]         i_tol,
    output lpgs_pkg::t_dpst     o_st,
    output logic signed [31:0]  o_z_value,
    output logic signed [31:0]  o_w_value
);
    import lpgs_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int MW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

    logic              row_ok;
    logic              col_ok;
    logic              m_we, q_we, z_we, w_we;
    logic [MW-1:0]     m_waddr, m_raddr;
    logic [IW-1:0]     z_waddr, w_waddr, q_waddr, q_raddr, v_raddr;
    logic signed [31:0] m_rd, q_rd, z_rd, w_rd;
    logic signed [31:0] z_wdata, z_eff, w_eff, w_sat, div_quo;
    logic              div_done;
    logic              w_ok;
    logic signed [ACC_W-1:0] prod_fl, acc_abs, q_ext;

    logic [MAX_SIZE-1:0]     r_z_vld, r_w_vld;
    logic                    r_z_vrd, r_w_vrd;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_min_ok;
    logic signed [31:0]      r_o_z, r_o_w;

    // Load decoding; out-of-range writes are dropped.
    assign row_ok  = int'(i_row) < MAX_SIZE;
    assign col_ok  = int'(i_col) < MAX_SIZE;
    assign m_we    = i_cmd.ld_wr && (i_req_type == REQ_MAT) && row_ok && col_ok;
    assign q_we    = i_cmd.ld_wr && (i_req_type == REQ_Q) && row_ok;
    assign z_we    = (i_cmd.ld_wr && (i_req_type == REQ_Z) && row_ok) || i_cmd.z_we;
    assign w_we    = i_cmd.w_we;
    assign m_waddr = MW'(int'(i_row) * MAX_SIZE + int'(i_col));
    assign m_raddr = MW'(int'(i_cmd.row) * MAX_SIZE + int'(i_cmd.col));
    assign q_waddr = IW'(i_row);
    assign q_raddr = IW'(i_cmd.row);
    assign v_raddr = IW'(i_cmd.col);
    assign z_waddr = i_cmd.z_we ? IW'(i_cmd.row) : IW'(i_row);
    assign w_waddr = IW'(i_cmd.row);
    assign z_wdata = i_cmd.z_we ? div_quo : i_value;

    lpgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE), .AW(MW)) u_m_ram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(i_value),
        .i_re(i_cmd.rd_en), .i_raddr(m_raddr), .o_rdata(m_rd)
    );
    lpgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE), .AW(IW)) u_q_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(i_value),
        .i_re(i_cmd.rd_en), .i_raddr(q_raddr), .o_rdata(q_rd)
    );
    lpgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE), .AW(IW)) u_z_ram (
        .i_clk(i_clk), .i_we(z_we), .i_waddr(z_waddr), .i_wdata(z_wdata),
        .i_re(i_cmd.rd_en), .i_raddr(v_raddr), .o_rdata(z_rd)
    );
    lpgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE), .AW(IW)) u_w_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_sat),
        .i_re(i_cmd.rd_en), .i_raddr(v_raddr), .o_rdata(w_rd)
    );

    // Valid bits: z and w entries read as zero until first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_vld <= '0;
            r_w_vld <= '0;
        end else begin
            if (z_we) begin
                r_z_vld[z_waddr] <= 1'b1;
            end
            if (w_we) begin
                r_w_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_z_vrd <= r_z_vld[v_raddr];
            r_w_vrd <= r_w_vld[v_raddr];
        end
    end

    assign z_eff = r_z_vrd ? z_rd : 32'sd0;
    assign w_eff = r_w_vrd ? w_rd : 32'sd0;

    // Product register: M*z for check and sweep, z*w for the dot product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= i_cmd.mul_dot ? (z_eff * w_eff) : (m_rd * z_eff);
        end
    end

    // Flooring the product is an arithmetic shift.
    assign prod_fl = r_prod >>> FRAC_BITS;
    assign q_ext   = {{(ACC_W-32){q_rd[31]}}, q_rd};

    // Exact accumulator.
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LDQ:  r_acc <= q_ext;
            ACC_LDNQ: r_acc <= -q_ext;
            ACC_ADD:  r_acc <= r_acc + prod_fl;
            ACC_SUB:  r_acc <= r_acc - prod_fl;
            ACC_CLR:  r_acc <= '0;
            default:  r_acc <= r_acc;
        endcase
    end

    assign w_sat = sat32(r_acc);
    assign w_ok  = $signed({w_sat[31], w_sat}) > -$signed({2'b00, i_tol});

    // Running minimum test over the w entries of one check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ok <= 1'b1;
        end else if (i_cmd.chk_init) begin
            r_min_ok <= 1'b1;
        end else if (i_cmd.w_we) begin
            r_min_ok <= r_min_ok & w_ok;
        end
    end

    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    lpgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_sat), .i_den(m_rd), .o_done(div_done), .o_quo(div_quo)
    );

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_z <= z_eff;
            r_o_w <= w_eff;
        end
    end

    assign o_st.diag_zero = (m_rd == 32'sd0);
    assign o_st.conv      = r_min_ok && (acc_abs < $signed({{(ACC_W-31){1'b0}}, i_tol}));
    assign o_st.div_done  = div_done;
    assign o_z_value      = r_o_z;
    assign o_w_value      = r_o_w;
endmodule

@@ rtl/core/lpgs_ctrl.sv @@
// Controller: sequences diagonal check, convergence checks, sweeps and results.
`timescale 1ns / 1ps
module lpgs_ctrl #(
    parameter int MAX_SIZE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_req_type,
    output logic                o_stall,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [3:0]          o_index,
    output logic [1:0]          o_status,
    output logic [15:0]         o_iterations,
    output logic                o_last,
    input  logic [4:0]          i_size,
    input  logic [15:0]         i_max_iter,
    output lpgs_pkg::t_cmd      o_cmd,
    input  lpgs_pkg::t_dpst     i_st
);
    import lpgs_pkg::*;

    localparam logic [4:0] LIM = (MAX_SIZE < 16) ? 5'(MAX_SIZE) : 5'd16;

    typedef enum logic [4:0] {
        S_IDLE, S_DG_RD, S_DG_CK, S_CI_RD, S_CI_LD, S_CM_RD, S_CM_MUL, S_CM_ACC,
        S_CW, S_DT_RD, S_DT_MUL, S_DT_ACC, S_DT_CK, S_SI_RD, S_SI_LD, S_SM_RD,
        S_SM_MUL, S_SM_ACC, S_SD_RD, S_SD_ST, S_SD_WT, S_OUT_RD, S_OUT_LD
    } t_state;

    t_state      r_state;
    t_idx        r_i, r_j, r_nm1;
    logic [15:0] r_k;
    logic        r_diag;
    t_status     r_status;
    logic [15:0] r_iter;
    logic        r_o_valid;
    t_idx        r_o_index;
    logic        r_o_last;
    t_status     r_o_status;
    logic [15:0] r_o_iter;

    logic       in_acc;
    logic       out_free;
    logic [4:0] n_sz;
    logic [4:0] n_act;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign n_sz     = (i_size == 5'd0) ? 5'd1 : i_size;
    assign n_act    = (n_sz > LIM) ? LIM : n_sz;

    // Command decode from the current state.
    always_comb begin
        o_cmd        = '0;
        o_cmd.row    = r_i;
        o_cmd.col    = r_j;
        o_cmd.acc_op = ACC_HOLD;
        unique case (r_state)
            S_IDLE:   o_cmd.ld_wr = in_acc && (i_req_type != REQ_START);
            S_DG_RD:  begin o_cmd.rd_en = 1'b1; o_cmd.col = r_i; end
            S_DG_CK:  o_cmd.chk_init = 1'b1;
            S_CI_RD:  o_cmd.rd_en = 1'b1;
            S_CI_LD:  o_cmd.acc_op = ACC_LDQ;
            S_CM_RD:  o_cmd.rd_en = 1'b1;
            S_CM_MUL: o_cmd.mul_en = 1'b1;
            S_CM_ACC: o_cmd.acc_op = ACC_ADD;
            S_CW:     begin o_cmd.w_we = 1'b1; o_cmd.acc_op = ACC_CLR; end
            S_DT_RD:  begin o_cmd.rd_en = 1'b1; o_cmd.col = r_i; end
            S_DT_MUL: begin o_cmd.mul_en = 1'b1; o_cmd.mul_dot = 1'b1; end
            S_DT_ACC: o_cmd.acc_op = ACC_ADD;
            S_DT_CK:  o_cmd.chk_init = 1'b1;
            S_SI_RD:  o_cmd.rd_en = 1'b1;
            S_SI_LD:  o_cmd.acc_op = ACC_LDNQ;
            S_SM_RD:  o_cmd.rd_en = 1'b1;
            S_SM_MUL: o_cmd.mul_en = 1'b1;
            S_SM_ACC: o_cmd.acc_op = (r_j != r_i) ? ACC_SUB : ACC_HOLD;
            S_SD_RD:  begin o_cmd.rd_en = 1'b1; o_cmd.col = r_i; end
            S_SD_ST:  o_cmd.div_start = 1'b1;
            S_SD_WT:  o_cmd.z_we = i_st.div_done;
            S_OUT_RD: begin o_cmd.rd_en = 1'b1; o_cmd.col = r_i; end
            S_OUT_LD: o_cmd.out_ld = out_free;
            default:  o_cmd.acc_op = ACC_HOLD;
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_i        <= '0;
            r_j        <= '0;
            r_nm1      <= '0;
            r_k        <= '0;
            r_diag     <= 1'b0;
            r_status   <= ST_CONV;
            r_iter     <= '0;
            r_o_valid  <= 1'b0;
            r_o_index  <= '0;
            r_o_last   <= 1'b0;
            r_o_status <= ST_CONV;
            r_o_iter   <= '0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req_type == REQ_START)) begin
                        r_nm1   <= 4'(n_act - 5'd1);
                        r_i     <= '0;
                        r_diag  <= 1'b0;
                        r_state <= S_DG_RD;
                    end
                end
                S_DG_RD: r_state <= S_DG_CK;
                S_DG_CK: begin
                    if (r_i == r_nm1) begin
                        r_i <= '0;
                        r_k <= '0;
                        if (r_diag || i_st.diag_zero) begin
                            r_status <= ST_DIAG;
                            r_iter   <= '0;
                            r_state  <= S_OUT_RD;
                        end else if (i_max_iter == 16'd0) begin
                            r_status <= ST_LIMIT;
                            r_iter   <= '0;
                            r_state  <= S_OUT_RD;
                        end else begin
                            r_state <= S_CI_RD;
                        end
                    end else begin
                        r_diag  <= r_diag | i_st.diag_zero;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DG_RD;
                    end
                end
                S_CI_RD: r_state <= S_CI_LD;
                S_CI_LD: begin
                    r_j     <= '0;
                    r_state <= S_CM_RD;
                end
                S_CM_RD:  r_state <= S_CM_MUL;
                S_CM_MUL: r_state <= S_CM_ACC;
                S_CM_ACC: begin
                    if (r_j == r_nm1) begin
                        r_state <= S_CW;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CM_RD;
                    end
                end
                S_CW: begin
                    if (r_i == r_nm1) begin
                        r_i     <= '0;
                        r_state <= S_DT_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CI_RD;
                    end
                end
                S_DT_RD:  r_state <= S_DT_MUL;
                S_DT_MUL: r_state <= S_DT_ACC;
                S_DT_ACC: begin
                    if (r_i == r_nm1) begin
                        r_state <= S_DT_CK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DT_RD;
                    end
                end
                S_DT_CK: begin
                    r_i <= '0;
                    if (i_st.conv) begin
                        r_status <= ST_CONV;
                        r_iter   <= r_k;
                        r_state  <= S_OUT_RD;
                    end else begin
                        r_state <= S_SI_RD;
                    end
                end
                S_SI_RD: r_state <= S_SI_LD;
                S_SI_LD: begin
                    r_j     <= '0;
                    r_state <= S_SM_RD;
                end
                S_SM_RD:  r_state <= S_SM_MUL;
                S_SM_MUL: r_state <= S_SM_ACC;
                S_SM_ACC: begin
                    if (r_j == r_nm1) begin
                        r_state <= S_SD_RD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SM_RD;
                    end
                end
                S_SD_RD: r_state <= S_SD_ST;
                S_SD_ST: r_state <= S_SD_WT;
                S_SD_WT: begin
                    if (i_st.div_done) begin
                        if (r_i == r_nm1) begin
                            r_i <= '0;
                            if (r_k + 16'd1 == i_max_iter) begin
                                r_status <= ST_LIMIT;
                                r_iter   <= i_max_iter;
                                r_state  <= S_OUT_RD;
                            end else begin
                                r_k     <= r_k + 16'd1;
                                r_state <= S_CI_RD;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_SI_RD;
                        end
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_index  <= r_i;
                        r_o_last   <= (r_i == r_nm1);
                        r_o_status <= r_status;
                        r_o_iter   <= r_iter;
                        if (r_i == r_nm1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_index      = r_o_index;
    assign o_status     = r_o_status;
    assign o_iterations = r_o_iter;
    assign o_last       = r_o_last;
endmodule
